// ===== sv/gwwlb_pkg.sv =====
`timescale 1ns / 1ps

package gwwlb_pkg;

	localparam int CHAR_W         = 8;
	localparam int LINE_WIDTH_DEF = 20;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

endpackage

// ===== sv/gwwlb_text_if.sv =====
`timescale 1ns / 1ps

interface gwwlb_text_if;
	import gwwlb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              text_last;

	modport source (output valid, output text_char, output text_last, input ready);
	modport sink   (input valid, input text_char, input text_last, output ready);

endinterface

// ===== sv/gwwlb_line_if.sv =====
`timescale 1ns / 1ps

interface gwwlb_line_if;
	import gwwlb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] line_char;
	logic              line_end;
	logic              text_end;

	modport source (output valid, output line_char, output line_end, output text_end,
		input ready);
	modport sink   (input valid, input line_char, input line_end, input text_end,
		output ready);

endinterface

// ===== sv/greedy_word_wrap_line_breaker_unit.sv =====
`timescale 1ns / 1ps

// Greedy word wrap for a character display of LINE_WIDTH columns.
// text (sink): one character byte per transfer, text_last on the final byte.
// line (source): one display character per transfer, line_end on the last
// character of each line, text_end on the last character of the text.
// Pending characters sit in a LINE_WIDTH-entry ring memory (one write or
// one read per cycle, read data lands straight in the output register).
// Steps per input transfer:
//   line not yet full: the byte is appended to the ring.
//   line full (a line is decided): the decided line of cut characters
//     is read out, one memory read per emitted character, then the byte
//     is appended unless it is dropped.
//   last of text: the pending characters are then flushed as well.
// The single memory port serves both the append and the line readout.
// The first character of a line appears on line in the cycle after its read.
// A stall on line holds the output register and pauses the readout; text
// is not taken while a line is being read out.
// Reset empties the pending line and the output register; memory contents
// are not cleared, only entries written since are ever read.
module greedy_word_wrap_line_breaker_unit #(
	parameter int LINE_WIDTH = gwwlb_pkg::LINE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	gwwlb_text_if.sink   text,
	gwwlb_line_if.source line
);
	import gwwlb_pkg::*;

	localparam int AW = $clog2(LINE_WIDTH);      // ring address
	localparam int CW = $clog2(LINE_WIDTH + 1);  // counts 0..LINE_WIDTH
	localparam int SW = CW + 1;                  // pointer sums before wrap

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_WRITE,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [CHAR_W-1:0] mem_q [LINE_WIDTH];

	// ring state
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     sp_pos_q;     // last space at line position 1 or later
	logic              sp_vld_q;
	logic              last_sp_q;    // last pending character is a space

	// held input while a decided line is read out
	logic [CHAR_W-1:0] char_q;
	logic              drop_q;
	logic              last_q;

	// readout engine
	logic [AW-1:0]     rd_addr_q;
	logic [CW-1:0]     rem_q;
	logic              te_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_le_q;
	logic              out_te_q;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
		logic [SW-1:0] y;
		y = (x >= SW'(LINE_WIDTH)) ? x - SW'(LINE_WIDTH) : x;
		return y[AW-1:0];
	endfunction

	logic              in_fire;
	logic              full;
	logic              is_sp;
	logic              use_sp;
	logic [CW-1:0]     cut;
	logic              cut_full;
	logic              drop_c;
	logic [AW-1:0]     head_new;
	logic [CW-1:0]     count_new;
	logic [AW-1:0]     wr_addr;
	logic              issue;
	logic              rd_last;
	logic [AW-1:0]     rd_addr_nx;
	logic [CW-1:0]     count_post;

	assign text.ready = (state_q == ST_IDLE);
	assign in_fire    = text.valid && text.ready;
	assign full       = (count_q == CW'(LINE_WIDTH));
	assign is_sp      = (text.text_char == SPACE_CHAR);

	// line decision, only used on a full line
	assign use_sp    = !is_sp && !last_sp_q && sp_vld_q;
	assign cut       = use_sp ? CW'(sp_pos_q) : CW'(LINE_WIDTH);
	assign cut_full  = !use_sp;
	assign drop_c    = cut_full && is_sp;
	assign head_new  = cut_full ? head_q : wrap(SW'(head_q) + SW'(cut) + SW'(1));
	assign count_new = cut_full ? '0 : CW'(LINE_WIDTH) - cut - CW'(1);

	assign wr_addr    = wrap(SW'(head_q) + SW'(count_q));
	assign count_post = count_q + CW'(!drop_q);

	assign issue      = ((state_q == ST_DRAIN) || (state_q == ST_FLUSH)) &&
		(rem_q != '0) && (!out_valid_q || line.ready);
	assign rd_last    = (rem_q == CW'(1));
	assign rd_addr_nx = wrap(SW'(rd_addr_q) + SW'(1));

	// memory: append port and readout into the output register
	always_ff @(posedge clk) begin
		if ((in_fire && !full) || (state_q == ST_WRITE && !drop_q)) begin
			mem_q[wr_addr] <= (state_q == ST_WRITE) ? char_q : text.text_char;
		end
		if (issue) begin
			out_char_q <= mem_q[rd_addr_q];
			out_le_q   <= rd_last;
			out_te_q   <= rd_last && te_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_q <= text.text_char;
			drop_q <= drop_c;
			last_q <= text.text_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			sp_pos_q    <= '0;
			sp_vld_q    <= 1'b0;
			last_sp_q   <= 1'b0;
			rd_addr_q   <= '0;
			rem_q       <= '0;
			te_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				rd_addr_q   <= rd_addr_nx;
				rem_q       <= rem_q - CW'(1);
			end else if (line.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire && !full) begin
						// append; a space at position zero is never a break point
						count_q   <= count_q + CW'(1);
						last_sp_q <= is_sp;
						if (is_sp && count_q != '0) begin
							sp_pos_q <= count_q[AW-1:0];
							sp_vld_q <= 1'b1;
						end
						if (text.text_last) begin
							rd_addr_q <= head_q;
							rem_q     <= count_q + CW'(1);
							te_q      <= 1'b1;
							state_q   <= ST_FLUSH;
						end
					end else if (in_fire) begin
						// full line: read out the decided part, then append
						rd_addr_q <= head_q;
						rem_q     <= cut;
						te_q      <= drop_c && text.text_last;
						head_q    <= head_new;
						count_q   <= count_new;
						sp_vld_q  <= 1'b0;
						last_sp_q <= 1'b0;
						state_q   <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (issue && rd_last) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// a last byte with nothing left pending ends at zero here
					count_q <= count_post;
					if (last_q && count_post != '0) begin
						rd_addr_q <= head_q;
						rem_q     <= count_post;
						te_q      <= 1'b1;
						state_q   <= ST_FLUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (issue && rd_last) begin
						count_q   <= '0;
						sp_vld_q  <= 1'b0;
						last_sp_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign line.valid     = out_valid_q;
	assign line.line_char = out_char_q;
	assign line.line_end  = out_le_q;
	assign line.text_end  = out_te_q;

endmodule

// ===== dv/gwwlb_wrap_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the pending line, and checks
// every display character against the wrap it predicts.
module gwwlb_wrap_checker #(
	parameter int LINE_WIDTH = gwwlb_pkg::LINE_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	gwwlb_text_if text,
	gwwlb_line_if line,
	output int    results_due,
	output int    fail_count,
	output int    lines_seen,
	output int    texts_seen
);
	import gwwlb_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              line_end;
		logic              text_end;
	} disp_char_t;

	logic [CHAR_W-1:0] held_chars [LINE_WIDTH];
	int                held_count;
	disp_char_t        line_chars_due [$];

	initial begin
		fail_count = 0;
		lines_seen = 0;
		texts_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic due_char(input logic [CHAR_W-1:0] ch, input logic le, input logic te);
		disp_char_t d;
		d.ch       = ch;
		d.line_end = le;
		d.text_end = te;
		line_chars_due = {line_chars_due, d};
	endtask

	// One accepted text byte: decide a full line if needed, append, flush on last.
	task automatic wrap_text_byte(input logic [CHAR_W-1:0] c, input logic last);
		int i;
		int cut;
		int rest;
		bit drop_c;
		if (held_count >= LINE_WIDTH) begin
			cut = LINE_WIDTH;
			// break at the last space past column 0, only between two non-spaces
			if (c != SPACE_CHAR && held_chars[LINE_WIDTH-1] != SPACE_CHAR)
				for (i = LINE_WIDTH - 1; i >= 1 && cut == LINE_WIDTH; i--)
					if (held_chars[i] == SPACE_CHAR)
						cut = i;
			drop_c = (cut == LINE_WIDTH) && (c == SPACE_CHAR);
			for (i = 0; i < cut; i++)
				due_char(held_chars[i], i + 1 == cut, (i + 1 == cut) && drop_c && last);
			if (cut < LINE_WIDTH) begin
				rest = LINE_WIDTH - cut - 1;
				for (i = 0; i < rest; i++)
					held_chars[i] = held_chars[cut + 1 + i];
				held_count = rest;
			end else begin
				held_count = 0;
			end
			if (!drop_c) begin
				held_chars[held_count] = c;
				held_count++;
			end
		end else begin
			held_chars[held_count] = c;
			held_count++;
		end
		if (last) begin
			for (i = 0; i < held_count; i++)
				due_char(held_chars[i], i + 1 == held_count, i + 1 == held_count);
			held_count = 0;
		end
	endtask

	task automatic check_line_char();
		disp_char_t want;
		if (line_chars_due.size() == 0) begin
			report_mismatch($sformatf("unexpected char %0h", line.line_char));
		end else begin
			want = line_chars_due.pop_front();
			if (line.line_char !== want.ch)
				report_mismatch($sformatf("line_char %0h, want %0h",
					line.line_char, want.ch));
			if (line.line_end !== want.line_end)
				report_mismatch($sformatf("line_end %0b, want %0b on char %0h",
					line.line_end, want.line_end, want.ch));
			if (line.text_end !== want.text_end)
				report_mismatch($sformatf("text_end %0b, want %0b on char %0h",
					line.text_end, want.text_end, want.ch));
		end
		if (line.line_end === 1'b1)
			lines_seen++;
		if (line.text_end === 1'b1)
			texts_seen++;
	endtask

	// predict before compare so a same-edge input never looks late
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			line_chars_due.delete();
			results_due <= 0;
		end else begin
			if (text.valid && text.ready)
				wrap_text_byte(text.text_char, text.text_last);
			if (line.valid && line.ready)
				check_line_char();
			results_due <= line_chars_due.size();
		end
	end

endmodule

// ===== dv/tb_greedy_word_wrap_line_breaker_unit.sv =====
`timescale 1ns / 1ps

// Drives texts into the word wrapper and lets the checker judge the lines.
module tb_greedy_word_wrap_line_breaker_unit;
	import gwwlb_pkg::*;

	localparam int LINE_WIDTH   = LINE_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 420;
	// watchdog limit, far above any quiet stretch of a correct run
	localparam int IDLE_LIMIT   = 2000;
	// after the last expected char, long enough for a stray extra line
	localparam int LINGER       = 2 * LINE_WIDTH + 20;

	logic clk;
	logic arst_n;

	gwwlb_text_if text_ch ();
	gwwlb_line_if line_ch ();

	int  results_due;
	int  fail_count;
	int  lines_seen;
	int  texts_seen;
	int  bytes_sent;
	bit  no_idle;      // burst stretch: neither side inserts gaps

	logic [CHAR_W-1:0] text_buf [$];

	greedy_word_wrap_line_breaker_unit #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.line  (line_ch)
	);

	gwwlb_wrap_checker #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.line       (line_ch),
		.results_due(results_due),
		.fail_count (fail_count),
		.lines_seen (lines_seen),
		.texts_seen (texts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Line sink: a random stall before each transfer, none in bursts.
	initial begin : line_sink
		int n;
		line_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				line_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			line_ch.ready <= 1'b1;
			do @(posedge clk); while (!(line_ch.valid && line_ch.ready));
		end
	end

	// Watchdog: too many cycles without any transfer on either side ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (line_ch.valid && line_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("greedy_word_wrap_line_breaker_unit test failed");
		$finish;
	end

	// One text byte: random gap, then hold valid until the transfer.
	// valid stays high into the next byte unless that one draws a gap.
	task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_char <= c;
		text_ch.text_last <= last;
		do @(posedge clk); while (!(text_ch.valid && text_ch.ready));
		bytes_sent++;
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Sender holds off until every predicted char has come out.
	// Called right at a transfer edge, so lowering valid is the only drive there.
	// The count is read at the falling edge, after the checker has updated it.
	task automatic drain_lines();
		text_ch.valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		@(posedge clk);
	endtask

	task automatic add_word(input int len);
		int i;
		logic [CHAR_W-1:0] b;
		for (i = 0; i < len; i++) begin
			b = CHAR_W'($urandom_range(0, 255));
			if (b == SPACE_CHAR)
				b = 8'hA0;
			text_buf = {text_buf, b};
		end
	endtask

	task automatic add_spaces(input int n);
		int i;
		for (i = 0; i < n; i++)
			text_buf = {text_buf, SPACE_CHAR};
	endtask

	initial begin : stimulus
		int n;
		int k;
		int len;
		arst_n            <= 1'b0;
		text_ch.valid     <= 1'b0;
		text_ch.text_char <= '0;
		text_ch.text_last <= 1'b0;
		bytes_sent = 0;
		no_idle    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a full line whose only space sits in column 0 must split
		// hard; the byte extremes ride along as line content.
		text_buf = '{SPACE_CHAR, 8'h00, 8'hFF, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'h21,
			8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h1F, 8'h55, 8'hAA, 8'hC3,
			8'h3C, 8'h0F};
		text_buf = {text_buf, 8'hF0};
		send_text();
		// a text of one space, then a tiny two-word text
		text_buf = '{SPACE_CHAR};
		send_text();
		text_buf = '{8'h61, SPACE_CHAR, 8'h62};
		send_text();
		drain_lines();

		// Random texts: mostly words with random bytes, plus shaped corner texts.
		while (bytes_sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			text_buf.delete();
			case ($urandom_range(0, 9))
				6: begin
					// exactly one full line, then a final space that gets dropped
					while (text_buf.size() < LINE_WIDTH) begin
						add_word($urandom_range(1, 8));
						add_spaces(1);
					end
					while (text_buf.size() > LINE_WIDTH)
						void'(text_buf.pop_back());
					add_spaces(1);
				end
				7: begin
					// leading space then a word at least as long as the line
					add_spaces(1);
					add_word($urandom_range(LINE_WIDTH, 2 * LINE_WIDTH));
				end
				8: begin
					len = $urandom_range(1, 45);
					for (n = 0; n < len; n++)
						text_buf = {text_buf, (($urandom_range(0, 3) == 0) ? SPACE_CHAR
							: CHAR_W'($urandom_range(0, 255)))};
				end
				9: begin
					len = $urandom_range(1, 3);
					for (n = 0; n < len; n++)
						text_buf = {text_buf, (($urandom_range(0, 1) == 0) ? SPACE_CHAR
							: CHAR_W'($urandom_range(0, 255)))};
				end
				default: begin
					// runs of spaces leave leading spaces on the next line
					k = $urandom_range(1, 12);
					if ($urandom_range(0, 5) == 0)
						add_spaces($urandom_range(1, 3));
					for (n = 0; n < k; n++) begin
						if (n > 0)
							add_spaces(($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1);
						add_word(($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
							: $urandom_range(1, 8));
					end
					if ($urandom_range(0, 5) == 0)
						add_spaces($urandom_range(1, 2));
				end
			endcase
			send_text();
			if ($urandom_range(0, 7) == 0)
				drain_lines();
		end

		drain_lines();
		repeat (LINGER) @(posedge clk);

		$display("covered %0d text bytes over %0d texts, %0d display lines checked",
			bytes_sent, texts_seen, lines_seen);
		$display("mismatches: %0d", fail_count);
		if (fail_count == 0)
			$display("greedy_word_wrap_line_breaker_unit test passed");
		else
			$display("greedy_word_wrap_line_breaker_unit test failed");
		$finish;
	end

endmodule

// ===== greedy_word_wrap_line_breaker_unit.f =====
sv/gwwlb_pkg.sv
sv/gwwlb_text_if.sv
sv/gwwlb_line_if.sv
sv/greedy_word_wrap_line_breaker_unit.sv
dv/gwwlb_wrap_checker.sv
dv/tb_greedy_word_wrap_line_breaker_unit.sv
